// File: rtl/core/temporal_range_aggregate_filter_core_defines.svh
// Assertion macros shared by the checker of the temporal range aggregate filter.
`ifndef TEMPORAL_RANGE_AGGREGATE_FILTER_CORE_DEFINES_SVH
`define TEMPORAL_RANGE_AGGREGATE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while the reset argument is high.
`define TRAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the reset argument is high.
`define TRAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/traf_pkg.sv
// Shared types, field layouts and codes of the temporal range aggregate filter.
package traf_pkg;

  localparam int ID_W    = 32;
  localparam int TIME_W  = 64;
  localparam int VAL_W   = 64;
  localparam int CNT_W   = 31;
  localparam int PAGE_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Input tdata layout, lowest bit first.
  localparam int IN_ID_LOW_LSB    = 0;
  localparam int IN_ID_HIGH_LSB   = IN_ID_LOW_LSB + ID_W;
  localparam int IN_TIME_LOW_LSB  = IN_ID_HIGH_LSB + ID_W;
  localparam int IN_TIME_HIGH_LSB = IN_TIME_LOW_LSB + TIME_W;
  localparam int IN_VMIN_LSB      = IN_TIME_HIGH_LSB + TIME_W;
  localparam int IN_VMAX_LSB      = IN_VMIN_LSB + VAL_W;
  localparam int IN_VTOTAL_LSB    = IN_VMAX_LSB + VAL_W;
  localparam int IN_VCOUNT_LSB    = IN_VTOTAL_LSB + VAL_W;
  localparam int IN_LEAF_BIT      = IN_VCOUNT_LSB + CNT_W;
  localparam int IN_NULL_BIT      = IN_LEAF_BIT + 1;
  localparam int IN_CHILD_LSB     = IN_NULL_BIT + 1;
  localparam int IN_USED_W        = IN_CHILD_LSB + PAGE_W;
  localparam int IN_DATA_W        = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_PAGE_LSB    = 0;
  localparam int OUT_MIN_LSB     = OUT_PAGE_LSB + PAGE_W;
  localparam int OUT_MAX_LSB     = OUT_MIN_LSB + VAL_W;
  localparam int OUT_TOTAL_LSB   = OUT_MAX_LSB + VAL_W;
  localparam int OUT_ENTRIES_LSB = OUT_TOTAL_LSB + VAL_W;
  localparam int OUT_EMPTY_BIT   = OUT_ENTRIES_LSB + CNT_W;
  localparam int OUT_USED_W      = OUT_EMPTY_BIT + 1;
  localparam int OUT_DATA_W      = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  typedef enum logic {
    ACT_ENTRY  = 1'b0,
    ACT_FINISH = 1'b1
  } action_t;

  typedef enum logic {
    KIND_DESCEND   = 1'b0,
    KIND_AGGREGATE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_KEY    = 2'd0,
    CFG_WINDOW_START = 2'd1,
    CFG_WINDOW_END   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    action_t                  action;
    logic signed [ID_W-1:0]   id_low;
    logic signed [ID_W-1:0]   id_high;
    logic signed [TIME_W-1:0] time_low;
    logic signed [TIME_W-1:0] time_high;
    logic signed [VAL_W-1:0]  value_min;
    logic signed [VAL_W-1:0]  value_max;
    logic signed [VAL_W-1:0]  value_total;
    logic [CNT_W-1:0]         value_count;
    logic                     leaf_page;
    logic                     null_entry;
    logic [PAGE_W-1:0]        child_page;
  } item_t;

  typedef struct packed {
    logic signed [ID_W-1:0]   query_key;
    logic signed [TIME_W-1:0] window_start;
    logic signed [TIME_W-1:0] window_end;
  } query_t;

  typedef struct packed {
    logic disjoint;
    logic contained;
  } class_t;

  typedef struct packed {
    kind_t                   kind;
    logic [PAGE_W-1:0]       descend_page;
    logic signed [VAL_W-1:0] min;
    logic signed [VAL_W-1:0] max;
    logic signed [VAL_W-1:0] total;
    logic [CNT_W-1:0]        entries;
    logic                    empty;
  } result_t;

endpackage

// File: rtl/core/traf_classify.sv
// Classifies an index entry against the query key and time window.
module traf_classify
  import traf_pkg::*;
(
  input  item_t  item,
  input  query_t query,
  output class_t cls
);

  always_comb begin
    cls.disjoint = (item.id_high < query.query_key) || (item.id_low > query.query_key) ||
                   (item.time_high < query.window_start) ||
                   (item.time_low > query.window_end);
    cls.contained = (item.id_low == query.query_key) && (item.id_high == query.query_key) &&
                    (item.time_low >= query.window_start) &&
                    (item.time_high <= query.window_end);
  end

endmodule

// File: rtl/core/traf_accum.sv
// Running aggregate: folds matching entries and forms descend and aggregate results.
module traf_accum
  import traf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  class_t  cls,
  output logic    emit,
  output result_t result
);

  logic signed [VAL_W-1:0] running_min;
  logic signed [VAL_W-1:0] running_max;
  logic signed [VAL_W-1:0] running_total;
  logic [CNT_W-1:0]        running_entries;

  logic              finish;
  logic              live;
  logic              fold;
  logic [CNT_W:0]    count_sum;
  logic [CNT_W-1:0]  entries_next;

  always_comb begin
    finish = (item.action == ACT_FINISH);
    live   = !finish && !item.null_entry && !cls.disjoint;
    fold   = live && (cls.contained || item.leaf_page);
    emit   = finish || (live && !cls.contained && !item.leaf_page);

    count_sum    = {1'b0, running_entries} + {1'b0, item.value_count};
    entries_next = count_sum[CNT_W] ? CNT_SAT : count_sum[CNT_W-1:0];

    result = '0;
    if (finish) begin
      result.kind = KIND_AGGREGATE;
      if (running_entries == '0) begin
        result.empty = 1'b1;
      end else begin
        result.min     = running_min;
        result.max     = running_max;
        result.total   = running_total;
        result.entries = running_entries;
      end
    end else begin
      result.kind         = KIND_DESCEND;
      result.descend_page = item.child_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min     <= VAL_MAX;
      running_max     <= VAL_MIN;
      running_total   <= '0;
      running_entries <= '0;
    end else if (fire) begin
      if (finish) begin
        running_min     <= VAL_MAX;
        running_max     <= VAL_MIN;
        running_total   <= '0;
        running_entries <= '0;
      end else if (fold) begin
        if (item.value_min < running_min) begin
          running_min <= item.value_min;
        end
        if (item.value_max > running_max) begin
          running_max <= item.value_max;
        end
        running_total   <= running_total + item.value_total;
        running_entries <= entries_next;
      end
    end
  end

endmodule

// File: rtl/core/temporal_range_aggregate_filter_core.sv
// Top level of the temporal range aggregate filter with stream ports and query registers.
// The input register holds an item until it advances; its result is then loaded into the
// output register. Throughput: one item per cycle unless a result waits on a stalled output;
// the accumulator fold is a feedback loop through the running aggregate registers.
// Reset (synchronous, active high) clears the query registers to zero, empties both
// stages and returns the running aggregate to its cleared state.
module temporal_range_aggregate_filter_core
  import traf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,    // action
  // entry_id_low, entry_id_high, entry_time_low, entry_time_high, entry_value_min,
  // entry_value_max, entry_value_total, entry_value_count, leaf_page, null_entry,
  // child_page, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  m_tuser,    // result_kind
  // descend_page, result_min, result_max, result_total, result_entries, result_empty
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  query_t  query;
  item_t   in_item;
  item_t   s_item;
  logic    in_valid;
  class_t  cls;
  logic    emit;
  logic    advance;
  result_t result;
  result_t out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUERY_KEY:    query.query_key    <= cfg_data[ID_W-1:0];
        CFG_WINDOW_START: query.window_start <= cfg_data[TIME_W-1:0];
        CFG_WINDOW_END:   query.window_end   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_item.action      = action_t'(s_tuser);
    s_item.id_low      = s_tdata[IN_ID_LOW_LSB +: ID_W];
    s_item.id_high     = s_tdata[IN_ID_HIGH_LSB +: ID_W];
    s_item.time_low    = s_tdata[IN_TIME_LOW_LSB +: TIME_W];
    s_item.time_high   = s_tdata[IN_TIME_HIGH_LSB +: TIME_W];
    s_item.value_min   = s_tdata[IN_VMIN_LSB +: VAL_W];
    s_item.value_max   = s_tdata[IN_VMAX_LSB +: VAL_W];
    s_item.value_total = s_tdata[IN_VTOTAL_LSB +: VAL_W];
    s_item.value_count = s_tdata[IN_VCOUNT_LSB +: CNT_W];
    s_item.leaf_page   = s_tdata[IN_LEAF_BIT];
    s_item.null_entry  = s_tdata[IN_NULL_BIT];
    s_item.child_page  = s_tdata[IN_CHILD_LSB +: PAGE_W];
  end

  assign advance  = in_valid && (!m_tvalid || m_tready || !emit);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  traf_classify u_classify (
    .item  (in_item),
    .query (query),
    .cls   (cls)
  );

  traf_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .cls    (cls),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= result;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tuser = out_result.kind;
    m_tdata[OUT_PAGE_LSB +: PAGE_W]   = out_result.descend_page;
    m_tdata[OUT_MIN_LSB +: VAL_W]     = out_result.min;
    m_tdata[OUT_MAX_LSB +: VAL_W]     = out_result.max;
    m_tdata[OUT_TOTAL_LSB +: VAL_W]   = out_result.total;
    m_tdata[OUT_ENTRIES_LSB +: CNT_W] = out_result.entries;
    m_tdata[OUT_EMPTY_BIT]            = out_result.empty;
  end

endmodule

// File: rtl/core/traf_checker.sv
// Port-level checker of the temporal range aggregate filter and its bind.
`include "temporal_range_aggregate_filter_core_defines.svh"

module traf_checker
  import traf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic                  m_tuser,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic is_aggregate;
  logic is_empty;

  assign is_aggregate = (m_tuser == KIND_AGGREGATE);
  assign is_empty     = m_tdata[OUT_EMPTY_BIT];

  `TRAF_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid, "output valid right after reset")
  `TRAF_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result transaction changed")
  `TRAF_ASSERT_SAME(a_descend_clean, clk, rst, m_tvalid && !is_aggregate, m_tdata[OUT_DATA_W-1:OUT_MIN_LSB] == '0, "descend request carries aggregate fields")
  `TRAF_ASSERT_SAME(a_empty_clean, clk, rst, m_tvalid && is_aggregate && is_empty, m_tdata[OUT_EMPTY_BIT-1:0] == '0, "empty aggregate carries nonzero fields")
  `TRAF_ASSERT_SAME(a_count_nonzero, clk, rst, m_tvalid && is_aggregate && !is_empty, m_tdata[OUT_ENTRIES_LSB +: CNT_W] != '0, "nonempty aggregate with zero count")

endmodule

bind temporal_range_aggregate_filter_core traf_checker u_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the temporal range aggregate filter core.
`timescale 1ns / 100ps

module testbench
  import traf_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [ID_W-1:0] ID_MIN = {1'b1, {(ID_W-1){1'b0}}};
  localparam logic signed [ID_W-1:0] ID_MAX = {1'b0, {(ID_W-1){1'b1}}};

  class aggregate_scoreboard;
    logic signed [ID_W-1:0] key;
    logic signed [TIME_W-1:0] win_start;
    logic signed [TIME_W-1:0] win_end;
    logic signed [VAL_W-1:0] run_min;
    logic signed [VAL_W-1:0] run_max;
    logic signed [VAL_W-1:0] run_total;
    logic [CNT_W-1:0] run_entries;
    result_t expected_q[$];
    int errors;
    int items_seen;
    int aggregates_seen;
    int descends_seen;

    function new();
      key = '0;
      win_start = '0;
      win_end = '0;
      errors = 0;
      items_seen = 0;
      aggregates_seen = 0;
      descends_seen = 0;
      clear_acc();
    endfunction

    function void clear_acc();
      run_min = VAL_MAX;
      run_max = VAL_MIN;
      run_total = '0;
      run_entries = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_QUERY_KEY: key = data[ID_W-1:0];
        CFG_WINDOW_START: win_start = data[TIME_W-1:0];
        CFG_WINDOW_END: win_end = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      result_t r;
      logic contained;
      logic [CNT_W:0] sum;
      items_seen++;
      r = '0;
      if (it.action == ACT_FINISH) begin
        r.kind = KIND_AGGREGATE;
        if (run_entries == '0) begin
          r.empty = 1'b1;
        end else begin
          r.min = run_min;
          r.max = run_max;
          r.total = run_total;
          r.entries = run_entries;
        end
        clear_acc();
        expected_q.push_back(r);
        return;
      end
      if (it.null_entry) return;
      if ($signed(it.id_high) < key || $signed(it.id_low) > key) return;
      if ($signed(it.time_high) < win_start || $signed(it.time_low) > win_end) return;
      contained = ($signed(it.id_low) == key) && ($signed(it.id_high) == key) &&
                  ($signed(it.time_low) >= win_start) && ($signed(it.time_high) <= win_end);
      if (contained || it.leaf_page) begin
        if ($signed(it.value_min) < run_min) run_min = it.value_min;
        if ($signed(it.value_max) > run_max) run_max = it.value_max;
        run_total = run_total + it.value_total;
        sum = run_entries + it.value_count;
        run_entries = sum[CNT_W] ? CNT_SAT : sum[CNT_W-1:0];
        return;
      end
      r.kind = KIND_DESCEND;
      r.descend_page = it.child_page;
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: mismatch in %s, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == KIND_AGGREGATE) aggregates_seen++;
      else descends_seen++;
      if (got.kind !== want.kind) report("result_kind", want.kind, got.kind);
      if (got.descend_page !== want.descend_page)
        report("descend_page", want.descend_page, got.descend_page);
      if (got.min !== want.min) report("result_min", want.min, got.min);
      if (got.max !== want.max) report("result_max", want.max, got.max);
      if (got.total !== want.total) report("result_total", want.total, got.total);
      if (got.entries !== want.entries) report("result_entries", want.entries, got.entries);
      if (got.empty !== want.empty) report("result_empty", want.empty, got.empty);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic                  s_tuser;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aggregate_scoreboard sb = new();
  item_t offered_item;
  bit calm;
  bit hold_request;
  int cycle_count;
  int settings_count;
  logic signed [ID_W-1:0] cur_key;
  logic signed [TIME_W-1:0] cur_ws;
  logic signed [TIME_W-1:0] cur_we;

  temporal_range_aggregate_filter_core uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser(m_tuser),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : monitors
    result_t got;
    if (!rst && cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    if (!rst && s_tvalid && s_tready) sb.note_item(offered_item);
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser);
      got.descend_page = m_tdata[OUT_PAGE_LSB +: PAGE_W];
      got.min = m_tdata[OUT_MIN_LSB +: VAL_W];
      got.max = m_tdata[OUT_MAX_LSB +: VAL_W];
      got.total = m_tdata[OUT_TOTAL_LSB +: VAL_W];
      got.entries = m_tdata[OUT_ENTRIES_LSB +: CNT_W];
      got.empty = m_tdata[OUT_EMPTY_BIT];
      sb.check_result(got);
    end
  end

  // The receiver stalls in short random bursts, or for one long stretch on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Value in [lo, hi] with the ends favored; any value when the range is inverted.
  function automatic logic signed [63:0] pick64(logic signed [63:0] lo, logic signed [63:0] hi);
    logic [63:0] span;
    logic [63:0] r;
    if (lo > hi) return rand64();
    span = hi - lo;
    r = rand64();
    if ($urandom_range(0, 3) == 0) r = $urandom_range(0, 1) ? 64'd0 : span;
    else if (span != '1) r = r % (span + 64'd1);
    return lo + r;
  endfunction

  function automatic item_t make_entry(
    logic signed [ID_W-1:0] idl, logic signed [ID_W-1:0] idh,
    logic signed [TIME_W-1:0] tl, logic signed [TIME_W-1:0] th,
    logic signed [VAL_W-1:0] vmin, logic signed [VAL_W-1:0] vmax,
    logic signed [VAL_W-1:0] vtot, logic [CNT_W-1:0] cnt,
    logic leaf, logic [PAGE_W-1:0] child);
    item_t it;
    it = '0;
    it.action = ACT_ENTRY;
    it.id_low = idl;
    it.id_high = idh;
    it.time_low = tl;
    it.time_high = th;
    it.value_min = vmin;
    it.value_max = vmax;
    it.value_total = vtot;
    it.value_count = cnt;
    it.leaf_page = leaf;
    it.child_page = child;
    return it;
  endfunction

  function automatic item_t finish_item();
    item_t it;
    it = '0;
    it.action = ACT_FINISH;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    logic signed [63:0] key64;
    logic signed [63:0] floor;
    key64 = cur_key;
    it.action = ACT_ENTRY;
    it.id_low = $urandom;
    it.id_high = $urandom;
    it.time_low = rand64();
    it.time_high = rand64();
    it.value_min = rand64();
    it.value_max = rand64();
    it.value_total = rand64();
    it.value_count = $urandom;
    it.leaf_page = $urandom_range(0, 1);
    it.null_entry = 1'b0;
    it.child_page = $urandom;
    if ($urandom_range(0, 3) != 0) it.value_count = $urandom_range(0, 1000);
    else if ($urandom_range(0, 1) == 0) it.value_count = CNT_SAT - $urandom_range(0, 1000);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.action = ACT_FINISH;
    end else if (pick < 32 || (pick >= 70 && pick < 80)) begin
      it.id_low = cur_key;
      it.id_high = cur_key;
      it.time_low = pick64(cur_ws, cur_we);
      it.time_high = pick64(it.time_low, cur_we);
      it.null_entry = (pick >= 70);
    end else if (pick < 70) begin
      it.id_low = pick64(ID_MIN, key64);
      it.id_high = pick64(key64, ID_MAX);
      it.time_low = pick64(VAL_MIN, cur_we);
      floor = ($signed(it.time_low) > cur_ws) ? it.time_low : cur_ws;
      it.time_high = pick64(floor, VAL_MAX);
      it.leaf_page = (pick < 52);
    end else begin
      it.null_entry = $urandom_range(0, 1);
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_ID_LOW_LSB +: ID_W] = it.id_low;
    d[IN_ID_HIGH_LSB +: ID_W] = it.id_high;
    d[IN_TIME_LOW_LSB +: TIME_W] = it.time_low;
    d[IN_TIME_HIGH_LSB +: TIME_W] = it.time_high;
    d[IN_VMIN_LSB +: VAL_W] = it.value_min;
    d[IN_VMAX_LSB +: VAL_W] = it.value_max;
    d[IN_VTOTAL_LSB +: VAL_W] = it.value_total;
    d[IN_VCOUNT_LSB +: CNT_W] = it.value_count;
    d[IN_LEAF_BIT] = it.leaf_page;
    d[IN_NULL_BIT] = it.null_entry;
    d[IN_CHILD_LSB +: PAGE_W] = it.child_page;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.action;
    s_tdata <= d;
    offered_item <= it;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUERY_KEY: cur_key = data[ID_W-1:0];
      CFG_WINDOW_START: cur_ws = data;
      CFG_WINDOW_END: cur_we = data;
      default: ;
    endcase
  endtask

  task automatic set_query(input logic signed [ID_W-1:0] k, input logic signed [63:0] ws,
                           input logic signed [63:0] we);
    write_reg(CFG_QUERY_KEY, {{(CFG_DATA_W-ID_W){k[ID_W-1]}}, k});
    write_reg(CFG_WINDOW_START, ws);
    write_reg(CFG_WINDOW_END, we);
    settings_count++;
  endtask

  // Stops offering items until every pending result is out, then lets the pipeline settle.
  task automatic drain(input int settle);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input bit with_hold, input bit with_pause);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 4) begin
        hold_request = 1'b1;
        burst_left = 40;
      end
      if (with_pause && i == n / 2) drain(0);
      if (burst_left > 0) begin
        burst_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
      send_item(random_item());
    end
    drain(SETTLE_CYCLES);
  endtask

  task automatic random_window(output logic signed [63:0] ws, output logic signed [63:0] we);
    logic signed [63:0] a;
    logic signed [63:0] b;
    a = rand64();
    b = rand64();
    ws = (a < b) ? a : b;
    we = (a < b) ? b : a;
  endtask

  initial begin : stimulus
    item_t it;
    logic signed [63:0] ws;
    logic signed [63:0] we;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_request = 1'b0;
    settings_count = 1;
    cur_key = '0;
    cur_ws = '0;
    cur_we = '0;
    offered_item = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset query: empty aggregate, then a zero-count entry whose minimum still counts.
    send_item(finish_item());
    send_item(make_entry(0, 0, 0, 0, -50, 9, 16, 0, 1'b0, 32'd1));
    send_item(make_entry(0, 0, 0, 0, 5, 7, 3, 2, 1'b0, 32'd2));
    send_item(finish_item());
    drain(SETTLE_CYCLES);

    // Lowest key with an unbounded window.
    set_query(ID_MIN, VAL_MIN, VAL_MAX);
    write_reg(CFG_SPARE, rand64());
    send_item(make_entry(ID_MIN, ID_MIN, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX,
                         CNT_SAT, 1'b0, '1));
    send_item(make_entry(ID_MIN, ID_MIN, VAL_MIN, VAL_MAX, 0, 0, 1, 5, 1'b1, '1));
    send_item(make_entry(ID_MIN + 1, ID_MAX, 0, 0, 1, 1, 1, 1, 1'b1, 32'd3));
    it = make_entry(ID_MIN, ID_MIN, 0, 0, -1, 1, 1, 1, 1'b1, 32'd4);
    it.null_entry = 1'b1;
    send_item(it);
    send_item(make_entry(ID_MIN, ID_MAX, 0, 0, 1, 1, 1, 1, 1'b0, '1));
    send_item(make_entry(ID_MIN, 0, 0, 0, 0, 0, 3, 1, 1'b1, 32'd5));
    it = '1;
    send_item(it);
    send_item(finish_item());
    drain(SETTLE_CYCLES);

    // Highest key and a window on the last instant.
    set_query(ID_MAX, VAL_MAX, VAL_MAX);
    send_item(make_entry(ID_MAX, ID_MAX, VAL_MAX, VAL_MAX, 10, 20, 30, 4, 1'b0, 32'd6));
    send_item(make_entry(ID_MAX, ID_MAX, 0, VAL_MAX - 1, 1, 1, 1, 1, 1'b1, 32'd7));
    send_item(make_entry(ID_MIN, ID_MAX - 1, VAL_MAX, VAL_MAX, 1, 1, 1, 1, 1'b1, 32'd8));
    send_item(make_entry(ID_MAX, ID_MAX, VAL_MAX, 0, 1, 1, 1, 1, 1'b1, 32'd9));
    send_item(make_entry(0, ID_MAX, VAL_MAX, VAL_MAX, 1, 1, 1, 1, 1'b0, 32'd0));
    send_item(finish_item());
    drain(SETTLE_CYCLES);

    // Inverted window.
    set_query(0, 100, -100);
    send_item(make_entry(0, 0, -200, 200, -7, 7, 11, 3, 1'b1, 32'd10));
    send_item(make_entry(0, 0, -50, 300, 1, 1, 1, 1, 1'b1, 32'd11));
    send_item(finish_item());
    drain(SETTLE_CYCLES);

    random_window(ws, we);
    set_query($urandom, ws, we);
    run_phase(140, 1'b0, 1'b1);

    set_query(ID_MIN, VAL_MIN, VAL_MAX);
    run_phase(130, 1'b0, 1'b0);

    set_query($urandom_range(0, 20) - 10, 1000, -1000);
    run_phase(120, 1'b0, 1'b0);

    set_query(ID_MAX, VAL_MAX - 1000, VAL_MAX);
    run_phase(130, 1'b1, 1'b0);

    ws = rand64();
    set_query($urandom, ws, ws + 50);
    run_phase(140, 1'b0, 1'b0);

    calm = 1'b1;
    random_window(ws, we);
    set_query($urandom, ws, we);
    run_phase(140, 1'b0, 1'b0);

    $display("Run covered %0d input transactions under %0d query settings.",
             sb.items_seen, settings_count);
    $display("It checked %0d aggregates and %0d descend requests, %0d mismatches.",
             sb.aggregates_seen, sb.descends_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
